### hw/rtl/sscc_pkg.sv
// Shared types, constants and register codes of the start/stop crank control.
package sscc_pkg;

   // Press latch window while authorization is outstanding, in milliseconds.
   localparam int LATCH_WINDOW_MS = 1000;

   // Default width of the millisecond timers.
   localparam int TIMER_BITS_DEF = 20;

   // Milliseconds per second, used to scale the crank limit.
   localparam int MS_PER_S = 1000;

   // Width that holds the largest crank limit in milliseconds (255 * 1000).
   localparam int CRANK_LIMIT_MS_BITS = 18;

   // Configuration port geometry.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes, taken from byte address bits [3:2].
   localparam logic [1:0] REG_CRANK_LIMIT = 2'd0;
   localparam logic [1:0] REG_SUPPRESS    = 2'd1;
   localparam logic [1:0] REG_CONDITION   = 2'd2;

   // Engine phase codes; any other code is neither stopped nor running.
   localparam logic [1:0] PHASE_STOPPED = 2'd0;
   localparam logic [1:0] PHASE_RUNNING = 2'd2;

   // Start permission selected by the crank condition register.
   typedef enum logic [1:0] {
      COND_NONE        = 2'd0,
      COND_BRAKE       = 2'd1,
      COND_CLUTCH_UP   = 2'd2,
      COND_CLUTCH_DOWN = 2'd3
   } crank_cond_type;

   // Register reset values.
   localparam logic [7:0]  CRANK_LIMIT_RESET = 8'd6;
   localparam logic [15:0] SUPPRESS_RESET    = 16'd0;
   localparam crank_cond_type CONDITION_RESET = COND_NONE;

   // Input word of one tick.
   typedef struct packed {
      logic [9:0] elapsed_ms;
      logic       ign_power;
      logic       button_level;
      logic [1:0] engine_phase;
      logic       brake_pressed;
      logic       clutch_up;
      logic       clutch_down;
      logic       crank_suppressed;
      logic       start_unauthorized;
   } req_data_type;

   // Result word of one tick.
   typedef struct packed {
      logic       starter_on;
      logic       stop_request;
      logic [7:0] press_count;
      logic       start_pending;
   } rsp_data_type;

   // Configuration register contents.
   typedef struct packed {
      logic [7:0]     crank_limit_s;
      logic [15:0]    startup_suppress_ms;
      crank_cond_type crank_condition;
   } cfg_type;

   // Single-bit control state carried from tick to tick.
   typedef struct packed {
      logic first_power;
      logic last_button;
      logic pending;
      logic starter;
   } flags_type;

endpackage

### hw/rtl/sscc_if.sv
// Valid/ready channel interfaces for the tick input and the result output.
interface sscc_req_if;
   import sscc_pkg::*;

   logic         valid;
   logic         ready;
   req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sscc_rsp_if;
   import sscc_pkg::*;

   logic         valid;
   logic         ready;
   rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sscc_csr.sv
// APB-style configuration registers of the crank control.
module sscc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sscc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sscc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sscc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output sscc_pkg::cfg_type                   cfg
);
   import sscc_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // Register write decode; an unused index leaves everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_CRANK_LIMIT: cfg_in.crank_limit_s       = csr_pwdata[7:0];
            REG_SUPPRESS:    cfg_in.startup_suppress_ms = csr_pwdata[15:0];
            REG_CONDITION:   cfg_in.crank_condition     = crank_cond_type'(csr_pwdata[1:0]);
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crank_limit_s       <= CRANK_LIMIT_RESET;
         cfg_ff.startup_suppress_ms <= SUPPRESS_RESET;
         cfg_ff.crank_condition     <= CONDITION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      case (reg_index)
         REG_CRANK_LIMIT: csr_prdata = CSR_DATA_BITS'(cfg_ff.crank_limit_s);
         REG_SUPPRESS:    csr_prdata = CSR_DATA_BITS'(cfg_ff.startup_suppress_ms);
         REG_CONDITION:   csr_prdata = CSR_DATA_BITS'(cfg_ff.crank_condition);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

### hw/rtl/sscc_step.sv
// Next-state and result logic for one tick of the crank control.
module sscc_step #(
   parameter int TIMER_BITS = sscc_pkg::TIMER_BITS_DEF
) (
   input  sscc_pkg::req_data_type  req,
   input  sscc_pkg::cfg_type       cfg,
   input  sscc_pkg::flags_type     flags_cur,
   input  logic [TIMER_BITS-1:0]   power_cur,
   input  logic [TIMER_BITS-1:0]   pending_cur,
   input  logic [TIMER_BITS-1:0]   crank_cur,
   input  logic [7:0]              toggle_cur,
   output sscc_pkg::flags_type     flags_nxt,
   output logic [TIMER_BITS-1:0]   power_nxt,
   output logic [TIMER_BITS-1:0]   pending_nxt,
   output logic [TIMER_BITS-1:0]   crank_nxt,
   output logic [7:0]              toggle_nxt,
   output sscc_pkg::rsp_data_type  rsp
);
   import sscc_pkg::*;

   // Compare width that holds both a timer and the crank limit in milliseconds.
   localparam int CMP_BITS = (TIMER_BITS > CRANK_LIMIT_MS_BITS) ? TIMER_BITS
                                                                : CRANK_LIMIT_MS_BITS;

   // Add elapsed time to a timer, holding at all ones.
   function automatic logic [TIMER_BITS-1:0] sat_add(input logic [TIMER_BITS-1:0] t,
                                                     input logic [9:0] d);
      logic [TIMER_BITS:0] sum;
      sum = {1'b0, t} + (TIMER_BITS+1)'(d);
      return sum[TIMER_BITS] ? {TIMER_BITS{1'b1}} : sum[TIMER_BITS-1:0];
   endfunction

   logic [TIMER_BITS-1:0]          power_add;
   logic [TIMER_BITS-1:0]          pending_add;
   logic [TIMER_BITS-1:0]          crank_add;
   logic [CRANK_LIMIT_MS_BITS-1:0] limit_ms;
   logic                           stopped;
   logic                           running;
   logic                           cond_fail;
   logic                           blocked;
   logic                           stop_req;

   assign power_add   = sat_add(power_cur, req.elapsed_ms);
   assign pending_add = sat_add(pending_cur, req.elapsed_ms);
   assign crank_add   = sat_add(crank_cur, req.elapsed_ms);
   assign limit_ms    = CRANK_LIMIT_MS_BITS'(cfg.crank_limit_s)
                        * CRANK_LIMIT_MS_BITS'(MS_PER_S);
   assign stopped     = req.engine_phase == PHASE_STOPPED;
   assign running     = req.engine_phase == PHASE_RUNNING;

   // Pedal condition required by the configured start permission.
   always_comb begin
      case (cfg.crank_condition)
         COND_BRAKE:       cond_fail = !req.brake_pressed;
         COND_CLUTCH_UP:   cond_fail = !req.clutch_up;
         COND_CLUTCH_DOWN: cond_fail = !req.clutch_down;
         default:          cond_fail = 1'b0;
      endcase
   end

   // Only a start from standstill can be blocked.
   assign blocked = stopped && (cond_fail || req.crank_suppressed || req.start_unauthorized);

   // Tick evaluation: power gate, suppression window, button edge, latch, starter drop.
   always_comb begin
      flags_nxt   = flags_cur;
      power_nxt   = power_add;
      pending_nxt = pending_add;
      crank_nxt   = crank_add;
      toggle_nxt  = toggle_cur;
      stop_req    = 1'b0;
      if (!req.ign_power) begin
         power_nxt = '0;
      end else begin
         if (flags_cur.first_power) begin
            power_nxt             = '0;
            flags_nxt.first_power = 1'b0;
         end
         if (power_nxt >= TIMER_BITS'(cfg.startup_suppress_ms)) begin
            // Rising button edge.
            if (req.button_level && !flags_cur.last_button) begin
               if (!blocked) begin
                  toggle_nxt = toggle_cur + 8'd1;
                  if (stopped) begin
                     if (!flags_nxt.starter) begin
                        crank_nxt = '0;
                     end
                     flags_nxt.starter = 1'b1;
                  end else if (running) begin
                     stop_req = 1'b1;
                  end
               end else if (stopped && req.start_unauthorized) begin
                  flags_nxt.pending = 1'b1;
                  pending_nxt       = '0;
               end
            end
            flags_nxt.last_button = req.button_level;

            // Latched press waiting for authorization.
            if (flags_nxt.pending) begin
               if (!stopped || pending_nxt >= TIMER_BITS'(LATCH_WINDOW_MS)) begin
                  flags_nxt.pending = 1'b0;
               end else if (!blocked) begin
                  flags_nxt.pending = 1'b0;
                  if (!flags_nxt.starter) begin
                     crank_nxt = '0;
                  end
                  flags_nxt.starter = 1'b1;
               end
            end

            // Starter release on running engine or crank timeout.
            if (flags_nxt.starter) begin
               if (running || CMP_BITS'(crank_nxt) >= CMP_BITS'(limit_ms)) begin
                  flags_nxt.starter = 1'b0;
               end
            end
         end
      end
   end

   assign rsp.starter_on    = flags_nxt.starter;
   assign rsp.stop_request  = stop_req;
   assign rsp.press_count   = toggle_nxt;
   assign rsp.start_pending = flags_nxt.pending;

endmodule

### hw/rtl/start_stop_button_crank_control.sv
// Top level of the start/stop push-button crank control.
//
// Each accepted word is one slow firmware tick and yields exactly one result word.
// A word passes an input register, next-state logic that also updates the control
// state, and a result register; a new word is taken every cycle while the result
// side keeps up. When the result register is held by backpressure, ready stays high
// only while the input register is empty, so at most one more word is taken.
// Configuration writes complete in the APB access cycle (pready is tied high) and
// are meant to occur while no tick is in flight. Timers are TIMER_BITS wide and
// saturate; crank timeout compares against crank_limit_s times 1000 milliseconds.
module start_stop_button_crank_control #(
   parameter int TIMER_BITS = sscc_pkg::TIMER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   sscc_req_if.sink                            req_chan,
   sscc_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sscc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [sscc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [sscc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import sscc_pkg::*;

   cfg_type               cfg;

   logic                  in_valid_ff;
   req_data_type          in_data_ff;
   logic                  rsp_valid_ff;
   rsp_data_type          rsp_data_ff;

   flags_type             flags_ff;
   flags_type             flags_in;
   logic [TIMER_BITS-1:0] power_ff;
   logic [TIMER_BITS-1:0] power_in;
   logic [TIMER_BITS-1:0] pending_ff;
   logic [TIMER_BITS-1:0] pending_in;
   logic [TIMER_BITS-1:0] crank_ff;
   logic [TIMER_BITS-1:0] crank_in;
   logic [7:0]            toggle_ff;
   logic [7:0]            toggle_in;
   rsp_data_type          rsp_data_in;

   logic                  advance;
   logic                  req_take;

   sscc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sscc_step #(
      .TIMER_BITS (TIMER_BITS)
   ) u_step (
      .req         (in_data_ff),
      .cfg         (cfg),
      .flags_cur   (flags_ff),
      .power_cur   (power_ff),
      .pending_cur (pending_ff),
      .crank_cur   (crank_ff),
      .toggle_cur  (toggle_ff),
      .flags_nxt   (flags_in),
      .power_nxt   (power_in),
      .pending_nxt (pending_in),
      .crank_nxt   (crank_in),
      .toggle_nxt  (toggle_in),
      .rsp         (rsp_data_in)
   );

   // The held word moves on when the result register is empty or being drained.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Handshake control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_chan.data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Control state, committed once per tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff.first_power <= 1'b1;
         flags_ff.last_button <= 1'b0;
         flags_ff.pending     <= 1'b0;
         flags_ff.starter     <= 1'b0;
         power_ff             <= '0;
         pending_ff           <= '0;
         crank_ff             <= '0;
         toggle_ff            <= '0;
      end else if (advance) begin
         flags_ff   <= flags_in;
         power_ff   <= power_in;
         pending_ff <= pending_in;
         crank_ff   <= crank_in;
         toggle_ff  <= toggle_in;
      end
   end

endmodule

### tb/tb_start_stop_button_crank_control.sv
// Self-checking testbench for the start/stop push-button crank control block.
`timescale 1ns / 1ps

module tb_start_stop_button_crank_control;
   import sscc_pkg::*;

   localparam int TMR_BITS = TIMER_BITS_DEF;
   localparam logic [TMR_BITS-1:0] TMR_MAX = '1;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] REG_UNUSED = 2'd3;
   localparam logic [1:0] PHASE_CRANKING = 2'd1;
   localparam logic [1:0] PHASE_UNKNOWN = 2'd3;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   int cycle_count = 0;
   int error_count = 0;
   int stall_left = 0;
   bit idle_on = 1'b0;

   sscc_req_if req_chan ();
   sscc_rsp_if rsp_chan ();

   start_stop_button_crank_control #(.TIMER_BITS(TMR_BITS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Register copies and control state that the prediction keeps.
   logic [7:0]          cfg_limit_s;
   logic [15:0]         cfg_suppress_ms;
   crank_cond_type      cfg_cond;
   logic                first_power;
   logic [TMR_BITS-1:0] power_ms;
   logic [TMR_BITS-1:0] pend_ms;
   logic [TMR_BITS-1:0] crank_ms;
   logic                prev_button;
   logic                press_pending;
   logic                starter_engaged;
   logic [7:0]          toggles;

   // Result words still owed by the block, oldest first.
   rsp_data_type crank_result_q[$];

   // Free-running clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Millisecond timer add that sticks at the top of its range.
   function automatic logic [TMR_BITS-1:0] add_sat(input logic [TMR_BITS-1:0] t,
                                                   input logic [9:0] d);
      logic [TMR_BITS:0] s;
      s = {1'b0, t} + (TMR_BITS+1)'(d);
      return s[TMR_BITS] ? TMR_MAX : s[TMR_BITS-1:0];
   endfunction

   // A press on a stopped engine is held back by a missing pedal switch,
   // by external suppression or by missing authorization.
   function automatic logic press_is_blocked(input req_data_type d, input logic stopped);
      if (!stopped)
         return 1'b0;
      case (cfg_cond)
         COND_BRAKE: if (!d.brake_pressed) return 1'b1;
         COND_CLUTCH_UP: if (!d.clutch_up) return 1'b1;
         COND_CLUTCH_DOWN: if (!d.clutch_down) return 1'b1;
         default: ;
      endcase
      return d.crank_suppressed || d.start_unauthorized;
   endfunction

   // The crank timer restarts only when the starter was not already engaged.
   task automatic start_cranking;
      if (!starter_engaged)
         crank_ms = '0;
      starter_engaged = 1'b1;
   endtask

   // Advances the control state by one tick and queues the result word it gives.
   task automatic compute_crank_result(input req_data_type d);
      rsp_data_type r;
      logic stopped;
      logic running;
      logic stop;
      stopped = d.engine_phase == PHASE_STOPPED;
      running = d.engine_phase == PHASE_RUNNING;
      stop = 1'b0;
      power_ms = add_sat(power_ms, d.elapsed_ms);
      pend_ms = add_sat(pend_ms, d.elapsed_ms);
      crank_ms = add_sat(crank_ms, d.elapsed_ms);
      if (!d.ign_power) begin
         power_ms = '0;
      end else begin
         if (first_power) begin
            power_ms = '0;
            first_power = 1'b0;
         end
         if (power_ms >= TMR_BITS'(cfg_suppress_ms)) begin
            // Rising button edge: count it and act, or latch it for later.
            if (d.button_level && !prev_button) begin
               if (!press_is_blocked(d, stopped)) begin
                  toggles = toggles + 8'd1;
                  if (stopped)
                     start_cranking();
                  else if (running)
                     stop = 1'b1;
               end else if (stopped && d.start_unauthorized) begin
                  press_pending = 1'b1;
                  pend_ms = '0;
               end
            end
            prev_button = d.button_level;
            // A latched press either lapses or starts cranking once unblocked.
            if (press_pending) begin
               if (!stopped || pend_ms >= LATCH_WINDOW_MS)
                  press_pending = 1'b0;
               else if (!press_is_blocked(d, stopped)) begin
                  press_pending = 1'b0;
                  start_cranking();
               end
            end
            // The starter releases once the engine runs or the crank time is up.
            if (starter_engaged) begin
               if (running)
                  starter_engaged = 1'b0;
               else if (int'(crank_ms) >= int'(cfg_limit_s) * MS_PER_S)
                  starter_engaged = 1'b0;
            end
         end
      end
      r.starter_on = starter_engaged;
      r.stop_request = stop;
      r.press_count = toggles;
      r.start_pending = press_pending;
      crank_result_q.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input int want, input int got);
      error_count++;
      if (error_count <= 40)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   // Result side: compare every accepted word with the oldest prediction.
   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (crank_result_q.size() == 0) begin
            report_mismatch("unexpected result word", 0, int'(rsp_chan.data));
         end else begin
            want = crank_result_q.pop_front();
            if (rsp_chan.data.starter_on !== want.starter_on)
               report_mismatch("starter_on", want.starter_on, rsp_chan.data.starter_on);
            if (rsp_chan.data.stop_request !== want.stop_request)
               report_mismatch("stop_request", want.stop_request, rsp_chan.data.stop_request);
            if (rsp_chan.data.press_count !== want.press_count)
               report_mismatch("press_count", want.press_count, rsp_chan.data.press_count);
            if (rsp_chan.data.start_pending !== want.start_pending)
               report_mismatch("start_pending", want.start_pending, rsp_chan.data.start_pending);
         end
      end
   end

   // Random result side backpressure, applied only while idle_on is set.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Offers one tick word, with an optional gap first, and predicts it once taken.
   task automatic send_tick(input req_data_type d);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= d;
      do @(posedge clock); while (!req_chan.ready);
      compute_crank_result(d);
   endtask

   // Stops sending and waits until every owed result word has come back.
   task automatic drain_results;
      req_chan.valid <= 1'b0;
      while (crank_result_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One APB write: setup cycle, access cycle, then the bus is released.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CRANK_LIMIT: cfg_limit_s = value[7:0];
         REG_SUPPRESS: cfg_suppress_ms = value[15:0];
         REG_CONDITION: cfg_cond = crank_cond_type'(value[1:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Writes all three registers once the block is idle; upper bits carry junk.
   task automatic set_config(input int unsigned limit, input int unsigned suppress,
                             input crank_cond_type cond);
      drain_results();
      write_reg(REG_CRANK_LIMIT, ($urandom & 32'hFFFF_FF00) | limit);
      write_reg(REG_SUPPRESS, ($urandom & 32'hFFFF_0000) | suppress);
      write_reg(REG_CONDITION, ($urandom & 32'hFFFF_FFFC) | 32'(cond));
   endtask

   // Powered tick with every pedal switch active and nothing suppressed.
   function automatic req_data_type plain_tick(input int unsigned ms, input logic btn,
                                               input logic [1:0] phase);
      req_data_type t;
      t = '0;
      t.elapsed_ms = ms[9:0];
      t.ign_power = 1'b1;
      t.button_level = btn;
      t.engine_phase = phase;
      t.brake_pressed = 1'b1;
      t.clutch_up = 1'b1;
      t.clutch_down = 1'b1;
      return t;
   endfunction

   // Power loss, the first power-up and the suppression window after it.
   task automatic test_power_up_suppression;
      req_data_type t;
      set_config(6, 500, COND_NONE);
      write_reg(REG_UNUSED, $urandom);
      t = plain_tick(0, 1'b1, PHASE_STOPPED);
      t.ign_power = 1'b0;
      send_tick(t);
      send_tick(plain_tick(1023, 1'b1, PHASE_STOPPED));
      send_tick(plain_tick(300, 1'b1, PHASE_STOPPED));
      send_tick(plain_tick(300, 1'b1, PHASE_STOPPED));
      t = plain_tick(0, 1'b0, PHASE_RUNNING);
      t.ign_power = 1'b0;
      send_tick(t);
      send_tick(plain_tick(10, 1'b0, PHASE_RUNNING));
   endtask

   // Stop requests, cranking, the crank timeout, phase three and a zero limit.
   task automatic test_start_and_stop;
      req_data_type t;
      set_config(1, 0, COND_NONE);
      send_tick(plain_tick(10, 1'b0, PHASE_RUNNING));
      // Blocking inputs have no effect on a running engine.
      t = plain_tick(10, 1'b1, PHASE_RUNNING);
      t.crank_suppressed = 1'b1;
      t.start_unauthorized = 1'b1;
      t.brake_pressed = 1'b0;
      send_tick(t);
      send_tick(plain_tick(10, 1'b0, PHASE_STOPPED));
      send_tick(plain_tick(10, 1'b1, PHASE_STOPPED));
      send_tick(plain_tick(1023, 1'b1, PHASE_UNKNOWN));
      send_tick(plain_tick(10, 1'b0, PHASE_UNKNOWN));
      send_tick(plain_tick(10, 1'b1, PHASE_UNKNOWN));
      set_config(0, 0, COND_NONE);
      send_tick(plain_tick(0, 1'b0, PHASE_STOPPED));
      send_tick(plain_tick(0, 1'b1, PHASE_STOPPED));
   endtask

   // Each pedal condition blocks a press when its switch is missing.
   task automatic test_start_conditions;
      req_data_type t;
      crank_cond_type c;
      for (int i = 1; i < 4; i++) begin
         c = crank_cond_type'(i);
         set_config(6, 0, c);
         send_tick(plain_tick(20, 1'b0, PHASE_RUNNING));
         t = plain_tick(20, 1'b1, PHASE_STOPPED);
         case (c)
            COND_BRAKE: t.brake_pressed = 1'b0;
            COND_CLUTCH_UP: t.clutch_up = 1'b0;
            default: t.clutch_down = 1'b0;
         endcase
         send_tick(t);
      end
      // External suppression blocks as well; a clean press then cranks.
      send_tick(plain_tick(20, 1'b0, PHASE_STOPPED));
      t = plain_tick(20, 1'b1, PHASE_STOPPED);
      t.crank_suppressed = 1'b1;
      send_tick(t);
      send_tick(plain_tick(20, 1'b0, PHASE_STOPPED));
      send_tick(plain_tick(20, 1'b1, PHASE_STOPPED));
   endtask

   // Presses latched while unauthorized: honored, lapsed by phase, lapsed by time.
   task automatic test_delayed_authorization;
      req_data_type t;
      set_config(6, 0, COND_NONE);
      send_tick(plain_tick(10, 1'b0, PHASE_STOPPED));
      t = plain_tick(10, 1'b1, PHASE_STOPPED);
      t.start_unauthorized = 1'b1;
      send_tick(t);
      t.elapsed_ms = 10'd500;
      send_tick(t);
      send_tick(plain_tick(100, 1'b1, PHASE_STOPPED));
      send_tick(plain_tick(10, 1'b0, PHASE_RUNNING));
      t = plain_tick(10, 1'b1, PHASE_STOPPED);
      t.start_unauthorized = 1'b1;
      send_tick(t);
      t.engine_phase = PHASE_CRANKING;
      send_tick(t);
      t = plain_tick(10, 1'b0, PHASE_STOPPED);
      t.start_unauthorized = 1'b1;
      send_tick(t);
      t.button_level = 1'b1;
      send_tick(t);
      t.elapsed_ms = 10'd1000;
      send_tick(t);
   endtask

   // Random ticks that mostly follow a plausible engine and button story,
   // with some fully random words mixed in. Long mode keeps power on outside the
   // fully random words and uses large steps so the millisecond timers can reach saturation.
   task automatic test_random_ticks(input int count, input bit long_ticks);
      req_data_type t;
      logic [$bits(req_data_type)-1:0] raw;
      logic btn;
      logic unauth;
      logic [1:0] phase;
      int r;
      btn = 1'b0;
      unauth = 1'b0;
      phase = PHASE_STOPPED;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            raw = $bits(req_data_type)'($urandom);
            t = raw;
         end else begin
            if ($urandom_range(0, 2) == 0)
               btn = !btn;
            // The engine tends to catch while the starter is engaged.
            if (starter_engaged && $urandom_range(0, 3) == 0)
               phase = 2'($urandom_range(1, 2));
            else if ($urandom_range(0, 6) == 0)
               phase = ($urandom_range(0, 9) == 0) ? PHASE_UNKNOWN
                                                    : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 4) == 0)
               unauth = $urandom_range(0, 2) == 0;
            r = $urandom_range(0, 9);
            if (long_ticks)
               t.elapsed_ms = (r != 0) ? 10'd1023 : 10'($urandom_range(0, 1023));
            else if (r < 7)
               t.elapsed_ms = 10'($urandom_range(0, 250));
            else if (r < 9)
               t.elapsed_ms = 10'($urandom_range(0, 1023));
            else
               t.elapsed_ms = ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
            t.ign_power = long_ticks ? 1'b1 : ($urandom_range(0, 39) != 0);
            t.button_level = btn;
            t.engine_phase = phase;
            t.brake_pressed = $urandom_range(0, 3) != 0;
            t.clutch_up = $urandom_range(0, 3) != 0;
            t.clutch_down = $urandom_range(0, 3) != 0;
            t.crank_suppressed = $urandom_range(0, 11) == 0;
            t.start_unauthorized = unauth;
         end
         send_tick(t);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      cfg_limit_s = CRANK_LIMIT_RESET;
      cfg_suppress_ms = SUPPRESS_RESET;
      cfg_cond = CONDITION_RESET;
      first_power = 1'b1;
      power_ms = '0;
      pend_ms = '0;
      crank_ms = '0;
      prev_button = 1'b0;
      press_pending = 1'b0;
      starter_engaged = 1'b0;
      toggles = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on = 1'b1;

      test_power_up_suppression();
      test_start_and_stop();
      test_start_conditions();
      test_delayed_authorization();

      set_config(6, 0, COND_NONE);
      test_random_ticks(150, 1'b0);
      set_config(0, 100, COND_BRAKE);
      test_random_ticks(150, 1'b0);
      set_config(1, 2000, COND_CLUTCH_UP);
      test_random_ticks(150, 1'b0);
      set_config(255, 0, COND_CLUTCH_DOWN);
      test_random_ticks(150, 1'b0);
      set_config($urandom_range(0, 255), 65535, crank_cond_type'($urandom_range(0, 3)));
      test_random_ticks(1050, 1'b1);

      // Final stretch runs with both sides always ready.
      idle_on = 1'b0;
      set_config($urandom_range(0, 8), $urandom_range(0, 300),
                 crank_cond_type'($urandom_range(0, 3)));
      test_random_ticks(100, 1'b0);

      drain_results();
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/sscc_pkg.sv
hw/rtl/sscc_if.sv
hw/rtl/sscc_csr.sv
hw/rtl/sscc_step.sv
hw/rtl/start_stop_button_crank_control.sv
tb/tb_start_stop_button_crank_control.sv
